### rtl/swdh_pkg.sv
// ----------------------------------------------------------------------------
// swdh_pkg
// Types, codes and helpers shared by the SWD host transaction engine.
// ----------------------------------------------------------------------------
`default_nettype none

package swdh_pkg;

  // Item command codes (in_tuser)
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_TSEL  = 3'd3;
  localparam logic [2:0] CMD_LRST  = 3'd4;

  // Ack codes as sampled LSB first
  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  // Transaction status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FAULT   = 3'd1;
  localparam logic [2:0] ST_DISCONN = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_PARITY  = 3'd4;

  // Sequence lengths and the retry limit after reset
  localparam logic [5:0] HDR_BITS     = 6'd8;
  localparam logic [5:0] ACK_BITS     = 6'd3;
  localparam logic [5:0] TSEL_IDLE    = 6'd4;
  localparam logic [5:0] LRST_ONES    = 6'd50;
  localparam logic [5:0] LRST_BITS    = 6'd52;
  localparam logic [3:0] RETRY_RESET  = 4'd4;

  typedef enum logic [11:0] {
    PH_IDLE   = 12'b0000_0000_0001,
    PH_HDR    = 12'b0000_0000_0010,
    PH_TRN    = 12'b0000_0000_0100,
    PH_ACK    = 12'b0000_0000_1000,
    PH_WTRN   = 12'b0000_0001_0000,
    PH_ETRN   = 12'b0000_0010_0000,
    PH_RDATA  = 12'b0000_0100_0000,
    PH_RTRN   = 12'b0000_1000_0000,
    PH_WRTRN  = 12'b0001_0000_0000,
    PH_WDATA  = 12'b0010_0000_0000,
    PH_TSIDLE = 12'b0100_0000_0000,
    PH_LRESET = 12'b1000_0000_0000
  } swdh_phase_t;

  typedef struct packed {
    swdh_phase_t phase;
    logic [5:0]  bit_count;
    logic [31:0] shift_word;
    logic [7:0]  header_byte;
    logic        running_parity;
    logic [2:0]  ack_bits;
    logic [3:0]  attempts;
    logic [2:0]  kind;
    logic [2:0]  last_status;
  } swdh_state_t;

  // Engine state after reset
  localparam swdh_state_t STATE_RESET = '{
    phase:          PH_IDLE,
    bit_count:      6'd0,
    shift_word:     32'd0,
    header_byte:    8'd0,
    running_parity: 1'b0,
    ack_bits:       3'd0,
    attempts:       4'd0,
    kind:           3'd0,
    last_status:    ST_OK
  };

  typedef struct packed {
    logic        ap_ndp;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_in;
  } swdh_item_t;

  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;
  } swdh_res_t;

  // Request header: start, APnDP, RnW, A[2], A[3], parity, stop, park
  function automatic logic [7:0] make_header(input logic ap, input logic rnw,
                                             input logic [1:0] a);
    logic par;
    par = ap ^ rnw ^ a[0] ^ a[1];
    return {1'b1, 1'b0, par, a[1], a[0], rnw, ap, 1'b1};
  endfunction

endpackage

`default_nettype wire

### rtl/swdh_step.sv
// ----------------------------------------------------------------------------
// swdh_step
// Next-state and result logic for one item of the SWD engine.
// ----------------------------------------------------------------------------
`default_nettype none

module swdh_step (
  input  wire  swdh_pkg::swdh_state_t cur,
  input  wire  [2:0]                  cmd,
  input  wire  swdh_pkg::swdh_item_t  item,
  input  wire  [3:0]                  retry_limit,
  output swdh_pkg::swdh_state_t       nxt,
  output swdh_pkg::swdh_res_t         res
);
  import swdh_pkg::*;

  logic        dout, drv, clk, done;
  logic [31:0] rd;
  logic [3:0]  lim;
  logic [2:0]  ack_new;
  logic [3:0]  att_inc;
  logic [5:0]  cnt_inc;
  logic        par_fin;
  logic        wbit;

  assign lim     = (retry_limit == 4'd0) ? 4'd1 : retry_limit;
  assign att_inc = cur.attempts + 4'd1;
  assign cnt_inc = cur.bit_count + 6'd1;
  assign par_fin = cur.running_parity ^ item.swdio_in;
  assign wbit    = cur.shift_word[cur.bit_count[4:0]];

  always_comb begin
    unique case (cur.bit_count[1:0])
      2'd0:    ack_new = cur.ack_bits | {2'b00, item.swdio_in};
      2'd1:    ack_new = cur.ack_bits | {1'b0, item.swdio_in, 1'b0};
      2'd2:    ack_new = cur.ack_bits | {item.swdio_in, 2'b00};
      default: ack_new = cur.ack_bits;
    endcase
  end

  always_comb begin
    nxt  = cur;
    dout = 1'b0;
    drv  = 1'b0;
    clk  = 1'b0;
    done = 1'b0;
    rd   = '0;

    if (cmd != CMD_TICK) begin
      if (cur.phase == PH_IDLE && cmd <= CMD_LRST) begin
        nxt.kind           = cmd;
        nxt.bit_count      = '0;
        nxt.running_parity = 1'b0;
        nxt.ack_bits       = '0;
        nxt.attempts       = '0;
        nxt.shift_word     = (cmd == CMD_READ) ? 32'd0 : item.write_data;
        unique case (cmd)
          CMD_READ:  nxt.header_byte = make_header(item.ap_ndp, 1'b1, item.reg_addr);
          CMD_WRITE: nxt.header_byte = make_header(item.ap_ndp, 1'b0, item.reg_addr);
          CMD_TSEL:  nxt.header_byte = make_header(1'b0, 1'b0, 2'd3);
          default:   nxt.header_byte = '0;
        endcase
        nxt.phase = (cmd == CMD_LRST) ? PH_LRESET : PH_HDR;
      end
    end else if (cur.phase != PH_IDLE) begin
      clk = 1'b1;
      unique case (cur.phase)
        PH_HDR: begin
          drv  = 1'b1;
          dout = cur.header_byte[cur.bit_count[2:0]];
          nxt.bit_count = cnt_inc;
          if (cnt_inc >= HDR_BITS) begin
            nxt.bit_count = '0;
            nxt.phase     = PH_TRN;
          end
        end
        PH_TRN: begin
          nxt.bit_count = '0;
          nxt.ack_bits  = '0;
          nxt.phase     = (cur.kind == CMD_TSEL) ? PH_TSIDLE : PH_ACK;
        end
        PH_ACK: begin
          nxt.ack_bits  = ack_new;
          nxt.bit_count = cnt_inc;
          if (cnt_inc >= ACK_BITS) begin
            nxt.bit_count = '0;
            nxt.attempts  = att_inc;
            if (ack_new == ACK_OK) begin
              nxt.running_parity = 1'b0;
              if (cur.kind == CMD_READ) begin
                nxt.shift_word = '0;
                nxt.phase      = PH_RDATA;
              end else begin
                nxt.phase = PH_WRTRN;
              end
            end else if (ack_new == ACK_WAIT) begin
              nxt.phase = PH_WTRN;
            end else begin
              nxt.phase = PH_ETRN;
            end
          end
        end
        PH_WTRN: begin
          if (cur.attempts >= lim) begin
            nxt.last_status = ST_TIMEOUT;
            nxt.phase       = PH_IDLE;
            done            = 1'b1;
          end else begin
            nxt.bit_count = '0;
            nxt.phase     = PH_HDR;
          end
        end
        PH_ETRN: begin
          nxt.last_status = (cur.ack_bits == ACK_FAULT) ? ST_FAULT : ST_DISCONN;
          nxt.phase       = PH_IDLE;
          done            = 1'b1;
        end
        PH_RDATA: begin
          if (!cur.bit_count[5]) begin
            nxt.shift_word[cur.bit_count[4:0]] = item.swdio_in;
            nxt.running_parity = par_fin;
            nxt.bit_count      = cnt_inc;
          end else begin
            nxt.running_parity = par_fin;
            if (par_fin) nxt.shift_word = '0;
            nxt.bit_count = '0;
            nxt.phase     = PH_RTRN;
          end
        end
        PH_RTRN: begin
          nxt.last_status = cur.running_parity ? ST_PARITY : ST_OK;
          rd              = cur.running_parity ? 32'd0 : cur.shift_word;
          nxt.phase       = PH_IDLE;
          done            = 1'b1;
        end
        PH_WRTRN: begin
          nxt.bit_count      = '0;
          nxt.running_parity = 1'b0;
          nxt.phase          = PH_WDATA;
        end
        PH_TSIDLE: begin
          nxt.bit_count = cnt_inc;
          if (cnt_inc >= TSEL_IDLE) begin
            nxt.bit_count      = '0;
            nxt.running_parity = 1'b0;
            nxt.phase          = PH_WDATA;
          end
        end
        PH_WDATA: begin
          drv = 1'b1;
          if (!cur.bit_count[5]) begin
            dout               = wbit;
            nxt.running_parity = cur.running_parity ^ wbit;
            nxt.bit_count      = cnt_inc;
          end else begin
            dout            = cur.running_parity;
            nxt.last_status = ST_OK;
            nxt.phase       = PH_IDLE;
            done            = 1'b1;
          end
        end
        PH_LRESET: begin
          drv  = 1'b1;
          dout = (cur.bit_count < LRST_ONES);
          nxt.bit_count = cnt_inc;
          if (cnt_inc >= LRST_BITS) begin
            nxt.last_status = ST_OK;
            nxt.phase       = PH_IDLE;
            done            = 1'b1;
          end
        end
        default: begin
          clk       = 1'b0;
          nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.swdio_out   = dout;
    res.swdio_drive = drv;
    res.clock_pulse = clk;
    res.busy_res    = (nxt.phase != PH_IDLE);
    res.done_res    = done;
    res.status      = nxt.last_status;
    res.read_data   = rd;
  end

endmodule

`default_nettype wire

### rtl/swd_host_transaction_engine_unit.sv
// ----------------------------------------------------------------------------
// swd_host_transaction_engine_unit
// Bit-level SWD host: one stream item per SWCLK cycle, one result per item.
// ----------------------------------------------------------------------------
// Usage: send a start item (in_tuser = read, write, target select or line
// reset) and then one tick item (in_tuser = 0) per SWCLK cycle. Every item
// produces exactly one result transaction telling whether this tick clocks
// the wire, what level to drive, whether SWDIO is released, and, on the done
// tick, the status and read word. Throughput is one item per clock; the result
// appears in the cycle after the item is taken, from a single output register.
// in_tready stays high while that register is empty or being drained, so the
// block streams at full rate whenever the sink keeps out_tready high. The
// transaction state advances only when an item is accepted. retry_limit may
// be rewritten through cfg_we/cfg_wdata while no transaction is running;
// a value of zero behaves as one attempt.
`default_nettype none

module swd_host_transaction_engine_unit (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: [0] ap_ndp, [2:1] reg_addr, [34:3] write_data, [35] swdio_in
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,
  // in_tuser: [2:0] cmd
  input  wire  [2:0]  in_tuser,
  // out_tdata: [0] swdio_out, [1] swdio_drive, [2] clock_pulse, [3] busy_res,
  //            [4] done_res, [7:5] status, [39:8] read_data
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,
  // retry_limit register
  input  wire         cfg_we,
  input  wire  [3:0]  cfg_wdata
);
  import swdh_pkg::*;

  swdh_state_t state_r, state_nxt;
  swdh_item_t  item;
  swdh_res_t   res;
  logic [3:0]  retry_limit_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic        in_fire;

  assign item.ap_ndp     = in_tdata[0];
  assign item.reg_addr   = in_tdata[2:1];
  assign item.write_data = in_tdata[34:3];
  assign item.swdio_in   = in_tdata[35];

  // Output register either empty or emptied this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  swdh_step u_step (
    .cur         (state_r),
    .cmd         (in_tuser),
    .item        (item),
    .retry_limit (retry_limit_r),
    .nxt         (state_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_RESET;
    end else if (cfg_we) begin
      retry_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {res.read_data, res.status, res.done_res, res.busy_res,
                     res.clock_pulse, res.swdio_drive, res.swdio_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
